/* design/ssfxy_pkg.sv */
// Shared types, constants and helper functions of the stereo sine XY synthesizer.
// No dependencies; used by ssfxy_ctrl, ssfxy_dp and the top level.
package ssfxy_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int DAC_BITS        = 12;
  localparam int SAMPLE_BITS     = 20;
  localparam int PHASE_W         = 32;
  localparam int POS_W           = SINE_TABLE_BITS - 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int SIN_W           = 19;
  localparam int ACC_W           = 40;

  // phase offsets, 32-bit turns
  localparam logic [31:0] OFS_0P2     = 32'd136713055;
  localparam logic [31:0] OFS_0P35    = 32'd239247846;
  localparam logic [31:0] OFS_0P4     = 32'd273426110;
  localparam logic [31:0] OFS_0P5     = 32'd341782638;
  localparam logic [31:0] OFS_0P7     = 32'd478495693;
  localparam logic [31:0] OFS_0P9     = 32'd615208748;
  localparam logic [31:0] OFS_1P0     = 32'd683565276;
  localparam logic [31:0] OFS_1P3     = 32'd888634858;
  localparam logic [31:0] OFS_QUARTER = 32'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESET, REG_LPF_ALPHA, REG_HPF_ALPHA, REG_MUTED,
    REG_STEP, REG_CODE_MIN, REG_CODE_MAX, REG_CENTER
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]          preset;
    logic [15:0]         lpf_alpha;
    logic [15:0]         hpf_alpha;
    logic                muted;
    logic [31:0]         step;
    logic [DAC_BITS-1:0] code_min;
    logic [DAC_BITS-1:0] code_max;
    logic [DAC_BITS-1:0] center_code;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_START, OP_SIN_PH, OP_SIN_X2, OP_SIN_T1, OP_SIN_T2, OP_SIN_S,
    OP_MAC, OP_PH_UPD, OP_MIX, OP_HP, OP_LP, OP_CODE_A, OP_CODE_B,
    OP_CODE_C, OP_CODE_D, OP_LOAD, OP_LOAD_CTR
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SIN_PH, S_SIN_X2, S_SIN_T1, S_SIN_T2, S_SIN_S, S_MAC,
    S_PH_UPD, S_MIX, S_HP, S_LP, S_CODE_A, S_CODE_B, S_CODE_C, S_CODE_D,
    S_LOAD, S_LOAD_CTR
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] term;
    logic [1:0] idx;
    logic       ch;
  } cmd_t;

  typedef struct packed {
    logic        right;
    logic [1:0]  src;
    logic [2:0]  mulk;
    logic [31:0] ofs;
    logic [15:0] weight;
  } term_t;

  function automatic term_t mk_term(logic right, logic [1:0] src, logic [2:0] mulk,
                                    logic [31:0] ofs, logic [15:0] weight);
    term_t t;
    t.right  = right;
    t.src    = src;
    t.mulk   = mulk;
    t.ofs    = ofs;
    t.weight = weight;
    return t;
  endfunction

  // one sine term of the weighted stereo sum
  function automatic term_t term_info(logic [1:0] preset, logic [2:0] term);
    term_t t;
    t = mk_term(1'b0, 2'd0, 3'd0, 32'd0, 16'd0);
    unique case (preset)
      2'd0: begin
        unique case (term)
          3'd0: t = mk_term(1'b0, 2'd0, 3'd1, 32'd0, 16'd39322);
          3'd1: t = mk_term(1'b0, 2'd1, 3'd1, 32'd0, 16'd14418);
          3'd2: t = mk_term(1'b0, 2'd2, 3'd1, 32'd0, 16'd7864);
          3'd3: t = mk_term(1'b0, 2'd3, 3'd1, 32'd0, 16'd3932);
          3'd4: t = mk_term(1'b1, 2'd0, 3'd1, OFS_0P9, 16'd39322);
          3'd5: t = mk_term(1'b1, 2'd1, 3'd1, OFS_0P4, 16'd13107);
          3'd6: t = mk_term(1'b1, 2'd2, 3'd1, OFS_1P3, 16'd9175);
          default: t = mk_term(1'b1, 2'd3, 3'd1, OFS_0P2, 16'd3932);
        endcase
      end
      2'd1: begin
        unique case (term)
          3'd0: t = mk_term(1'b0, 2'd0, 3'd1, 32'd0, 16'd51118);
          3'd1: t = mk_term(1'b0, 2'd1, 3'd1, 32'd0, 16'd14418);
          3'd2: t = mk_term(1'b1, 2'd0, 3'd1, OFS_QUARTER, 16'd51118);
          3'd3: t = mk_term(1'b1, 2'd1, 3'd1, OFS_0P35, 16'd14418);
          default: t = mk_term(1'b0, 2'd0, 3'd0, 32'd0, 16'd0);
        endcase
      end
      2'd2: begin
        unique case (term)
          3'd0: t = mk_term(1'b0, 2'd0, 3'd1, 32'd0, 16'd47186);
          3'd1: t = mk_term(1'b0, 2'd0, 3'd3, 32'd0, 16'd15729);
          3'd2: t = mk_term(1'b0, 2'd0, 3'd5, 32'd0, 16'd9175);
          3'd3: t = mk_term(1'b0, 2'd0, 3'd7, 32'd0, 16'd5243);
          3'd4: t = mk_term(1'b1, 2'd0, 3'd1, OFS_0P7, 16'd47186);
          3'd5: t = mk_term(1'b1, 2'd0, 3'd3, OFS_0P2, 16'd15729);
          3'd6: t = mk_term(1'b1, 2'd0, 3'd5, OFS_1P0, 16'd9175);
          default: t = mk_term(1'b1, 2'd0, 3'd7, OFS_0P5, 16'd5243);
        endcase
      end
      default: t = mk_term(1'b0, 2'd0, 3'd0, 32'd0, 16'd0);
    endcase
    return t;
  endfunction

  function automatic logic [3:0] num_terms(logic [1:0] preset);
    logic [3:0] n;
    unique case (preset)
      2'd0:    n = 4'd8;
      2'd1:    n = 4'd4;
      2'd2:    n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // tone frequency in units of 10 Hz for each accumulator
  function automatic logic [9:0] ph_mult(logic [1:0] preset, logic [1:0] idx);
    logic [9:0] k;
    k = 10'd0;
    unique case (preset)
      2'd0: begin
        unique case (idx)
          2'd0:    k = 10'd18;
          2'd1:    k = 10'd73;
          2'd2:    k = 10'd260;
          default: k = 10'd620;
        endcase
      end
      2'd1:    k = (idx == 2'd0) ? 10'd22 : ((idx == 2'd1) ? 10'd44 : 10'd0);
      2'd2:    k = (idx == 2'd0) ? 10'd21 : 10'd0;
      default: k = 10'd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd1 <<< (SAMPLE_BITS - 1);
    lo = -hi;
    hi = hi - 48'sd1;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

/* design/ssfxy_ctrl.sv */
// Sequencer of the stereo sine XY synthesizer: issues one datapath op per cycle.
// OP_IDLE is issued while waiting for input or output. Depends on ssfxy_pkg.
module ssfxy_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  ssfxy_pkg::cfg_t   cfg,
  input  logic              in_valid,
  input  logic              in_frame_start,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ssfxy_pkg::cmd_t   cmd
);

  ssfxy_pkg::state_t state_r, state_nxt;
  logic [2:0] term_r, term_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ch_r, ch_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] nterms;
  logic       out_free;

  assign nterms   = ssfxy_pkg::num_terms(cfg.preset);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ssfxy_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssfxy_pkg::S_IDLE;
      term_r      <= 3'd0;
      idx_r       <= 2'd0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_r      <= term_nxt;
      idx_r       <= idx_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    idx_nxt   = idx_r;
    ch_nxt    = ch_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op   = ssfxy_pkg::OP_IDLE;
    cmd.term = term_r;
    cmd.idx  = idx_r;
    cmd.ch   = ch_r;
    unique case (state_r)
      ssfxy_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op   = ssfxy_pkg::OP_START;
          term_nxt = 3'd0;
          idx_nxt  = 2'd0;
          ch_nxt   = 1'b0;
          if (cfg.muted) begin
            if (in_frame_start) state_nxt = ssfxy_pkg::S_LOAD_CTR;
          end else if (nterms == 4'd0) begin
            state_nxt = ssfxy_pkg::S_PH_UPD;
          end else begin
            state_nxt = ssfxy_pkg::S_SIN_PH;
          end
        end
      end
      ssfxy_pkg::S_SIN_PH: begin
        cmd.op = ssfxy_pkg::OP_SIN_PH;
        state_nxt = ssfxy_pkg::S_SIN_X2;
      end
      ssfxy_pkg::S_SIN_X2: begin
        cmd.op = ssfxy_pkg::OP_SIN_X2;
        state_nxt = ssfxy_pkg::S_SIN_T1;
      end
      ssfxy_pkg::S_SIN_T1: begin
        cmd.op = ssfxy_pkg::OP_SIN_T1;
        state_nxt = ssfxy_pkg::S_SIN_T2;
      end
      ssfxy_pkg::S_SIN_T2: begin
        cmd.op = ssfxy_pkg::OP_SIN_T2;
        state_nxt = ssfxy_pkg::S_SIN_S;
      end
      ssfxy_pkg::S_SIN_S: begin
        cmd.op = ssfxy_pkg::OP_SIN_S;
        state_nxt = ssfxy_pkg::S_MAC;
      end
      ssfxy_pkg::S_MAC: begin
        cmd.op = ssfxy_pkg::OP_MAC;
        if ({1'b0, term_r} == nterms - 4'd1) begin
          idx_nxt   = 2'd0;
          state_nxt = ssfxy_pkg::S_PH_UPD;
        end else begin
          term_nxt  = term_r + 3'd1;
          state_nxt = ssfxy_pkg::S_SIN_PH;
        end
      end
      ssfxy_pkg::S_PH_UPD: begin
        cmd.op  = ssfxy_pkg::OP_PH_UPD;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) state_nxt = ssfxy_pkg::S_MIX;
      end
      ssfxy_pkg::S_MIX: begin
        cmd.op    = ssfxy_pkg::OP_MIX;
        ch_nxt    = 1'b0;
        state_nxt = ssfxy_pkg::S_HP;
      end
      ssfxy_pkg::S_HP: begin
        cmd.op = ssfxy_pkg::OP_HP;
        state_nxt = ssfxy_pkg::S_LP;
      end
      ssfxy_pkg::S_LP: begin
        cmd.op = ssfxy_pkg::OP_LP;
        state_nxt = ssfxy_pkg::S_CODE_A;
      end
      ssfxy_pkg::S_CODE_A: begin
        cmd.op = ssfxy_pkg::OP_CODE_A;
        state_nxt = ssfxy_pkg::S_CODE_B;
      end
      ssfxy_pkg::S_CODE_B: begin
        cmd.op = ssfxy_pkg::OP_CODE_B;
        state_nxt = ssfxy_pkg::S_CODE_C;
      end
      ssfxy_pkg::S_CODE_C: begin
        cmd.op = ssfxy_pkg::OP_CODE_C;
        state_nxt = ssfxy_pkg::S_CODE_D;
      end
      ssfxy_pkg::S_CODE_D: begin
        cmd.op = ssfxy_pkg::OP_CODE_D;
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = ssfxy_pkg::S_HP;
        end else begin
          state_nxt = ssfxy_pkg::S_LOAD;
        end
      end
      ssfxy_pkg::S_LOAD: begin
        if (out_free) begin
          cmd.op        = ssfxy_pkg::OP_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = ssfxy_pkg::S_IDLE;
        end
      end
      ssfxy_pkg::S_LOAD_CTR: begin
        if (out_free) begin
          cmd.op        = ssfxy_pkg::OP_LOAD_CTR;
          out_valid_nxt = 1'b1;
          state_nxt     = ssfxy_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssfxy_pkg::S_IDLE;
    endcase
  end

endmodule

/* design/ssfxy_dp.sv */
// Datapath of the stereo sine XY synthesizer: phases, sine unit, mixer, filters, coder.
// Depends on ssfxy_pkg; driven by ssfxy_ctrl commands.
module ssfxy_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ssfxy_pkg::cfg_t                  cfg,
  input  ssfxy_pkg::cmd_t                  cmd,
  input  logic                             in_frame_start,
  input  logic                             in_restart,
  output logic [ssfxy_pkg::DAC_BITS-1:0]   out_x_code,
  output logic [ssfxy_pkg::DAC_BITS-1:0]   out_y_code,
  output logic                             out_blank_before
);

  localparam int SB = ssfxy_pkg::SAMPLE_BITS;
  localparam int DB = ssfxy_pkg::DAC_BITS;
  localparam int TB = ssfxy_pkg::SINE_TABLE_BITS;
  localparam int PW = ssfxy_pkg::POS_W;

  // architectural state
  logic [31:0]          ph_r [4];
  logic signed [SB-1:0] hpi_r [2];
  logic signed [SB-1:0] hpo_r [2];
  logic signed [SB-1:0] lpo_r [2];

  // working registers
  logic                  fs_r;
  logic [TB-1:0]         arg_r;
  logic [1:0]            quad_r;
  logic [16:0]           x_r, x2_r, t_r;
  logic signed [ssfxy_pkg::SIN_W-1:0] s_r;
  logic signed [ssfxy_pkg::ACC_W-1:0] accl_r, accr_r;
  logic signed [SB-1:0]  xin_r [2];
  logic signed [17:0]    v_r;
  logic signed [19:0]    span_r;
  logic                  neg_r;
  logic [39:0]           mag_r;
  logic [36:0]           prod_r;
  logic [DB-1:0]         code_r [2];
  logic [DB-1:0]         ox_r, oy_r;
  logic                  ob_r;

  ssfxy_pkg::term_t tinfo;
  logic [1:0]    ph_addr;
  logic [31:0]   ph_sel;
  logic [31:0]   arg_full;
  logic [31:0]   ph_inc;
  logic [16:0]   xq;
  logic [33:0]   mul_a;
  logic [29:0]   mul_c;
  logic [17:0]   t_wide;
  logic signed [35:0] mac_p;
  logic signed [ssfxy_pkg::ACC_W-1:0] mix_l, mix_r;
  logic signed [SB-1:0] hpo_c, hpi_c, lpo_c, xin_c;
  logic signed [21:0] hp_d;
  logic signed [38:0] hp_p;
  logic signed [20:0] lp_d;
  logic signed [37:0] lp_p;
  logic signed [47:0] flt_w;
  logic signed [SB-1:0] hp_new, lp_new;
  logic signed [12:0] span_d;
  logic [35:0]   base;
  logic signed [40:0] num;
  logic [40:0]   a_w;
  logic [13:0]   qm;
  logic signed [14:0] q, lo_s, hi_s;
  logic [DB-1:0] code_c;

  assign tinfo   = ssfxy_pkg::term_info(cfg.preset, cmd.term);
  assign ph_addr = (cmd.op == ssfxy_pkg::OP_PH_UPD) ? cmd.idx : tinfo.src;
  assign ph_sel  = ph_r[ph_addr];
  assign hpo_c   = hpo_r[cmd.ch];
  assign hpi_c   = hpi_r[cmd.ch];
  assign lpo_c   = lpo_r[cmd.ch];
  assign xin_c   = xin_r[cmd.ch];

  always_comb begin
    arg_full = 32'(ph_sel * 32'(tinfo.mulk)) + tinfo.ofs;
    ph_inc   = 32'(cfg.step * 32'(ssfxy_pkg::ph_mult(cfg.preset, cmd.idx)));
    // quarter-wave position, mirrored in odd quadrants
    xq = 17'(arg_r[PW-1:0]) << (16 - PW);
    if (arg_r[TB-2]) xq = 17'd65536 - xq;
    mul_a = 34'(x_r) * 34'(x_r);
    mul_c = 30'(x2_r) * 30'd4929;
    t_wide = 18'd0;
    unique case (cmd.op)
      ssfxy_pkg::OP_SIN_T1: begin
        mul_a  = 34'(xq) * 34'(xq);
        t_wide = 18'd42337 - 18'(mul_c[29:16]);
      end
      ssfxy_pkg::OP_SIN_T2: begin
        mul_a  = 34'(t_r) * 34'(x2_r);
        t_wide = 18'd102944 - 18'(mul_a[33:16]);
      end
      ssfxy_pkg::OP_SIN_S: mul_a = 34'(t_r) * 34'(x_r);
      ssfxy_pkg::OP_SIN_X2: mul_a = 34'(xq) * 34'(xq);
      default: mul_a = 34'(x_r) * 34'(x_r);
    endcase
    mac_p = $signed({1'b0, tinfo.weight}) * 36'(s_r);
    mix_l = (accl_r + 40'sd32768) >>> 16;
    mix_r = (accr_r + 40'sd32768) >>> 16;

    // one-pole high-pass: alpha*(prev_out + x - prev_in), rounded
    hp_d  = 22'(hpo_c) + 22'(xin_c) - 22'(hpi_c);
    hp_p  = $signed({1'b0, cfg.hpf_alpha}) * 39'(hp_d);
    flt_w = 48'((hp_p + 39'sd16384) >>> 15);
    hp_new = ssfxy_pkg::sat_sample(flt_w);
    // one-pole low-pass on the stored high-pass output
    lp_d  = 21'(hpo_c) - 21'(lpo_c);
    lp_p  = $signed({1'b0, cfg.lpf_alpha}) * 38'(lp_d);
    flt_w = 48'((lp_p + 38'sd16384) >>> 15) + 48'(lpo_c);
    lp_new = ssfxy_pkg::sat_sample(flt_w);

    // code = round(((lo+hi)*6553600 + 90*(hi-lo)*v) / 13107200)
    span_d = $signed({1'b0, cfg.code_max}) - $signed({1'b0, cfg.code_min});
    base   = 36'(13'({1'b0, cfg.code_min} + {1'b0, cfg.code_max})) * 36'd6553600;
    num    = $signed({5'b0, base}) + 41'(span_r * 38'(v_r));
    a_w    = 41'(mag_r) + 41'd6553600;
    qm     = prod_r[36:23];
    q      = neg_r ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    lo_s   = $signed({3'b0, cfg.code_min});
    hi_s   = $signed({3'b0, cfg.code_max});
    if (q < lo_s)      code_c = cfg.code_min;
    else if (q > hi_s) code_c = cfg.code_max;
    else               code_c = q[DB-1:0];
  end

  // state with defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) ph_r[i] <= 32'd0;
      for (int i = 0; i < 2; i++) begin
        hpi_r[i] <= '0;
        hpo_r[i] <= '0;
        lpo_r[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        ssfxy_pkg::OP_START: begin
          if (in_restart) begin
            for (int i = 0; i < 4; i++) ph_r[i] <= 32'd0;
            for (int i = 0; i < 2; i++) begin
              hpi_r[i] <= '0;
              hpo_r[i] <= '0;
              lpo_r[i] <= '0;
            end
          end
        end
        ssfxy_pkg::OP_PH_UPD: ph_r[cmd.idx] <= ph_sel + ph_inc;
        ssfxy_pkg::OP_HP: begin
          hpi_r[cmd.ch] <= xin_c;
          hpo_r[cmd.ch] <= hp_new;
        end
        ssfxy_pkg::OP_LP: lpo_r[cmd.ch] <= lp_new;
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ssfxy_pkg::OP_START: begin
        fs_r   <= in_frame_start;
        accl_r <= '0;
        accr_r <= '0;
      end
      ssfxy_pkg::OP_SIN_PH: arg_r <= arg_full[31 -: TB];
      ssfxy_pkg::OP_SIN_X2: begin
        quad_r <= arg_r[TB-1 -: 2];
        x_r    <= xq;
        x2_r   <= mul_a[32:16];
      end
      ssfxy_pkg::OP_SIN_T1: t_r <= t_wide[16:0];
      ssfxy_pkg::OP_SIN_T2: t_r <= t_wide[16:0];
      ssfxy_pkg::OP_SIN_S: begin
        if (quad_r[1]) s_r <= -$signed({1'b0, mul_a[33:16]});
        else           s_r <= $signed({1'b0, mul_a[33:16]});
      end
      ssfxy_pkg::OP_MAC: begin
        if (tinfo.right) accr_r <= accr_r + 40'(mac_p);
        else             accl_r <= accl_r + 40'(mac_p);
      end
      ssfxy_pkg::OP_MIX: begin
        xin_r[0] <= mix_l[SB-1:0];
        xin_r[1] <= mix_r[SB-1:0];
      end
      ssfxy_pkg::OP_CODE_A: begin
        if (lpo_c > 20'sd65536)       v_r <= 18'sd65536;
        else if (lpo_c < -20'sd65536) v_r <= -18'sd65536;
        else                          v_r <= lpo_c[17:0];
        span_r <= 20'(span_d * 20'sd90);
      end
      ssfxy_pkg::OP_CODE_B: begin
        neg_r <= num[40];
        mag_r <= num[40] ? 40'(-num) : num[39:0];
      end
      ssfxy_pkg::OP_CODE_C: prod_r <= 37'(a_w[36:19]) * 37'd335545;
      ssfxy_pkg::OP_CODE_D: code_r[cmd.ch] <= code_c;
      ssfxy_pkg::OP_LOAD: begin
        ox_r <= code_r[0];
        oy_r <= code_r[1];
        ob_r <= fs_r;
      end
      ssfxy_pkg::OP_LOAD_CTR: begin
        ox_r <= cfg.center_code;
        oy_r <= cfg.center_code;
        ob_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_x_code       = ox_r;
  assign out_y_code       = oy_r;
  assign out_blank_before = ob_r;

endmodule

/* design/stereo_sine_synth_filter_xy_core.sv */
// Top level of the stereo sine XY synthesizer: configuration registers, sequencer, datapath.
// Depends on ssfxy_pkg, ssfxy_ctrl and ssfxy_dp.
//
// Each input beat (frame_start, restart) yields one XY point as DAC codes, except that in
// muted mode only a frame start yields a point (the centre code, blank_before set). An
// unmuted sample runs one shared sine unit and its multiplier through the preset's terms,
// each term as phase, square, three polynomial steps and a weighted accumulate, then
// four phase updates, one mix step and the high-pass, low-pass and code steps per channel;
// preset 3 has no terms and goes straight to the phase updates. Every point ends in one output load.
// The input is taken only while the sequencer is idle; the finished point sits in an
// output register, so the next beat is accepted while it waits. Restart clears phases and
// filter state in the accept cycle. Configuration writes are always ready.
module stereo_sine_synth_filter_xy_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_frame_start,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ssfxy_pkg::DAC_BITS-1:0]      out_x_code,
  output logic [ssfxy_pkg::DAC_BITS-1:0]      out_y_code,
  output logic                                out_blank_before,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssfxy_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssfxy_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ssfxy_pkg::cfg_t cfg_r;
  ssfxy_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preset      <= 2'd0;
      cfg_r.lpf_alpha   <= 16'd32768;
      cfg_r.hpf_alpha   <= 16'd32768;
      cfg_r.muted       <= 1'b0;
      cfg_r.step        <= 32'd894785;
      cfg_r.code_min    <= '0;
      cfg_r.code_max    <= '1;
      cfg_r.center_code <= ssfxy_pkg::DAC_BITS'(2048);
    end else if (cfg_valid && cfg_ready) begin
      unique case (ssfxy_pkg::cfg_reg_t'(cfg_index))
        ssfxy_pkg::REG_PRESET:    cfg_r.preset      <= cfg_data[1:0];
        ssfxy_pkg::REG_LPF_ALPHA: cfg_r.lpf_alpha   <= cfg_data[15:0];
        ssfxy_pkg::REG_HPF_ALPHA: cfg_r.hpf_alpha   <= cfg_data[15:0];
        ssfxy_pkg::REG_MUTED:     cfg_r.muted       <= cfg_data[0];
        ssfxy_pkg::REG_STEP:      cfg_r.step        <= cfg_data[31:0];
        ssfxy_pkg::REG_CODE_MIN:  cfg_r.code_min    <= cfg_data[ssfxy_pkg::DAC_BITS-1:0];
        ssfxy_pkg::REG_CODE_MAX:  cfg_r.code_max    <= cfg_data[ssfxy_pkg::DAC_BITS-1:0];
        ssfxy_pkg::REG_CENTER:    cfg_r.center_code <= cfg_data[ssfxy_pkg::DAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  ssfxy_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd)
  );

  ssfxy_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .in_frame_start   (in_frame_start),
    .in_restart       (in_restart),
    .out_x_code       (out_x_code),
    .out_y_code       (out_y_code),
    .out_blank_before (out_blank_before)
  );

endmodule

/* sim/stereo_sine_synth_filter_xy_core_tb.sv */
// Self-checking bench for stereo_sine_synth_filter_xy_core: directed and random point requests,
// an in-bench XY point predictor held in a small scoreboard class.
// Depends on ssfxy_pkg (register indexes, widths) and the core.
module stereo_sine_synth_filter_xy_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssfxy_pkg::*;

  typedef struct {
    logic [DAC_BITS-1:0] x;
    logic [DAC_BITS-1:0] y;
    logic                blank;
  } xy_point_t;

  int unsigned err_cnt = 0;

  // one line per mismatch
  task automatic report(string what, longint got, longint want);
    err_cnt++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // Point predictor plus store of the points still owed by the core.
  class xy_scoreboard;
    logic [31:0] ph[4];
    longint hp_in[2], hp_out[2], lp[2];
    logic [1:0]  preset;
    longint      lpa, hpa;
    bit          muted;
    logic [31:0] stp;
    longint      cmin, cmax, ctr;
    xy_point_t   owed[$];

    function new();
      clear();
      preset = 0; lpa = 32768; hpa = 32768; muted = 0;
      stp = 32'd894785; cmin = 0; cmax = 4095; ctr = 2048;
    endfunction

    function void clear();
      for (int i = 0; i < 4; i++) ph[i] = '0;
      for (int i = 0; i < 2; i++) begin
        hp_in[i] = 0; hp_out[i] = 0; lp[i] = 0;
      end
    endfunction

    function void write_reg(cfg_reg_t r, logic [31:0] d);
      case (r)
        REG_PRESET:    preset = d[1:0];
        REG_LPF_ALPHA: lpa = d[15:0];
        REG_HPF_ALPHA: hpa = d[15:0];
        REG_MUTED:     muted = d[0];
        REG_STEP:      stp = d;
        REG_CODE_MIN:  cmin = d[11:0];
        REG_CODE_MAX:  cmax = d[11:0];
        default:       ctr = d[11:0];
      endcase
    endfunction

    // floor division by 2^n
    function longint fsh(longint v, int n);
      return v >>> n;
    endfunction

    function longint sat(longint v);
      longint hi;
      hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint sine(logic [31:0] p);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [1:0] q;
      longint x, x2, t;
      idx = p[31 -: SINE_TABLE_BITS];
      q = idx[SINE_TABLE_BITS-1 -: 2];
      x = longint'(idx[POS_W-1:0]) << (16 - POS_W);
      if (q[0]) x = 65536 - x;
      x2 = (x * x) >> 16;
      t = 42337 - ((4929 * x2) >> 16);
      t = 102944 - ((t * x2) >> 16);
      t = (t * x) >> 16;
      return q[1] ? -t : t;
    endfunction

    function longint filt(int ch, longint x);
      longint d, hp, l;
      d = hp_out[ch] + x - hp_in[ch];
      hp = sat(fsh(hpa * d + 16384, 15));
      hp_in[ch] = x;
      hp_out[ch] = hp;
      l = sat(lp[ch] + fsh(lpa * (hp - lp[ch]) + 16384, 15));
      lp[ch] = l;
      return l;
    endfunction

    function logic [11:0] code(longint v);
      longint den, num, q;
      den = 13107200;
      if (v > 65536) v = 65536;
      if (v < -65536) v = -65536;
      num = (cmin + cmax) * 100 * 65536 + 90 * (cmax - cmin) * v;
      if (num >= 0) q = (num + den / 2) / den;
      else q = -((-num + den / 2) / den);
      if (q < cmin) q = cmin;
      else if (q > cmax) q = cmax;
      return q[11:0];
    endfunction

    // accepted input beat
    function void note_input(bit fs, bit rs);
      logic [31:0] a, b, c, d;
      longint al, ar;
      xy_point_t pt;
      if (rs) clear();
      if (muted) begin
        if (fs) begin
          pt.x = ctr[11:0]; pt.y = ctr[11:0]; pt.blank = 1'b1;
          owed.push_back(pt);
        end
        return;
      end
      a = ph[0]; b = ph[1]; c = ph[2]; d = ph[3];
      al = 0; ar = 0;
      case (preset)
        2'd0: begin
          al = 39322 * sine(a) + 14418 * sine(b) + 7864 * sine(c) + 3932 * sine(d);
          ar = 39322 * sine(a + OFS_0P9) + 13107 * sine(b + OFS_0P4)
             + 9175 * sine(c + OFS_1P3) + 3932 * sine(d + OFS_0P2);
          ph[0] = a + stp * 32'd18;  ph[1] = b + stp * 32'd73;
          ph[2] = c + stp * 32'd260; ph[3] = d + stp * 32'd620;
        end
        2'd1: begin
          al = 51118 * sine(a) + 14418 * sine(b);
          ar = 51118 * sine(a + OFS_QUARTER) + 14418 * sine(b + OFS_0P35);
          ph[0] = a + stp * 32'd22; ph[1] = b + stp * 32'd44;
        end
        2'd2: begin
          al = 47186 * sine(a) + 15729 * sine(a * 32'd3)
             + 9175 * sine(a * 32'd5) + 5243 * sine(a * 32'd7);
          ar = 47186 * sine(a + OFS_0P7) + 15729 * sine(a * 32'd3 + OFS_0P2)
             + 9175 * sine(a * 32'd5 + OFS_1P0) + 5243 * sine(a * 32'd7 + OFS_0P5);
          ph[0] = a + stp * 32'd21;
        end
        default: ;
      endcase
      pt.x = code(filt(0, fsh(al + 32768, 16)));
      pt.y = code(filt(1, fsh(ar + 32768, 16)));
      pt.blank = fs;
      owed.push_back(pt);
    endfunction

    // accepted output beat
    task check_point(logic [11:0] x, logic [11:0] y, logic bl);
      xy_point_t e;
      if (owed.size() == 0) begin
        report("unexpected point", x, -1);
        return;
      end
      e = owed.pop_front();
      if (x !== e.x) report("x_code", x, e.x);
      if (y !== e.y) report("y_code", y, e.y);
      if (bl !== e.blank) report("blank_before", bl, e.blank);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_frame_start = 1'b0, in_restart = 1'b0;
  logic in_stall;
  logic out_valid, out_blank_before;
  logic out_stall = 1'b0;
  logic [DAC_BITS-1:0] out_x_code, out_y_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  xy_scoreboard sb = new();
  int unsigned hold_cycles = 0;   // long receiver hold-off request
  bit quiet_out = 1'b0;           // no new random stalls while set

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stereo_sine_synth_filter_xy_core u_dut (.*);

  // Output side: sample at the edge, then pick the stall for the next cycle.
  int unsigned out_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_point(out_x_code, out_y_code, out_blank_before);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall && !quiet_out && $urandom_range(0, 3) == 0)
          out_wait <= $urandom_range(0, 19);
      end
    end
  end

  // one input beat, preceded by gap cycles with valid low; gap 0 keeps valid high
  task automatic send_point(bit fs, bit rs, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_start <= fs;
    in_restart <= rs;
    do @(posedge clk); while (in_stall);
    sb.note_input(fs, rs);
  endtask

  // drop valid after the last beat of a burst
  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_gap(output int g);
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
  endtask

  // wait for all owed points, then allow the longest sample to drain
  task automatic drain();
    stop_input();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // register write; core must be idle
  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(r, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_points(int n, int restart_pct);
    int g;
    for (int i = 0; i < n; i++) begin
      pick_gap(g);
      send_point($urandom_range(0, 7) == 0, $urandom_range(0, 99) < restart_pct, g);
    end
  endtask

  initial begin
    int g;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: reset settings, frame start / restart combos
    send_point(1, 0, 0); send_point(0, 0, 0); send_point(1, 1, 0); send_point(0, 1, 3);
    drain();
    // each preset incl. the silent one, extreme code window and alphas
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_PRESET, p);
      send_point(0, 1, 0); send_point(1, 0, 0); send_point(0, 0, 0);
      drain();
    end
    write_reg(REG_PRESET, 0);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_LPF_ALPHA, 16'hFFFF);   // above one: saturating filters
    write_reg(REG_HPF_ALPHA, 16'hFFFF);
    send_point(0, 0, 0); send_point(0, 0, 0); send_point(1, 0, 0);
    drain();
    write_reg(REG_LPF_ALPHA, 0);
    write_reg(REG_HPF_ALPHA, 0);
    write_reg(REG_CODE_MIN, 12'hFFF);     // min above max
    write_reg(REG_CODE_MAX, 12'h000);
    send_point(0, 0, 0); send_point(1, 1, 0);
    drain();
    // muted: no point without frame start, restart still clears
    write_reg(REG_MUTED, 1);
    write_reg(REG_CENTER, 12'hFFF);
    send_point(0, 0, 0); send_point(1, 0, 0); send_point(0, 1, 0); send_point(1, 1, 0);
    drain();
    write_reg(REG_CENTER, 0);
    send_point(1, 0, 0);
    drain();

    // Random phases with varied settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_PRESET, (ph % 4 == 3) ? $urandom_range(0, 3) : ph % 4);
      write_reg(REG_LPF_ALPHA, (ph == 5) ? $urandom : $urandom_range(0, 32768));
      write_reg(REG_HPF_ALPHA, (ph == 6) ? 32768 : $urandom_range(0, 32768));
      write_reg(REG_STEP, $urandom);
      write_reg(REG_CODE_MIN, (ph < 2) ? 0 : $urandom_range(0, 1500));
      write_reg(REG_CODE_MAX, (ph < 2) ? 4095 : $urandom_range(2500, 4095));
      write_reg(REG_CENTER, $urandom);
      write_reg(REG_MUTED, (ph == 4 || ph == 9));
      if (ph == 4 || ph == 9) begin
        for (int i = 0; i < 200; i++) begin
          pick_gap(g);
          send_point($urandom_range(0, 2) == 0, $urandom_range(0, 9) == 0, g);
        end
      end else
        random_points(95, 3);
      if (ph == 3) begin
        // long receiver hold-off while sender keeps offering
        hold_cycles = 600;
        random_points(10, 0);
        // sender pauses until everything has come out
        stop_input();
        while (sb.owed.size() != 0) @(posedge clk);
        random_points(10, 0);
      end
      if (ph == 7) begin
        quiet_out = 1'b1;
        for (int i = 0; i < 30; i++) send_point($urandom_range(0, 1), 0, 0);
        quiet_out = 1'b0;
      end
      drain();
    end

    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

/* files.f */
design/ssfxy_pkg.sv
design/ssfxy_ctrl.sv
design/ssfxy_dp.sv
design/stereo_sine_synth_filter_xy_core.sv
sim/stereo_sine_synth_filter_xy_core_tb.sv
